[hw/rtl/wfbp_pkg.sv]
// Shared constants, codes and record types for the beacon parser.
package wfbp_pkg;

	localparam int MAX_SSID_BYTES  = 32;
	localparam int MAX_FRAME_BYTES = 4096;
	localparam int HDR_BYTES       = 24;
	localparam int FIXED_BYTES     = 12;
	localparam int TAGS_START      = HDR_BYTES + FIXED_BYTES;

	localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int SIDX_W = $clog2(MAX_SSID_BYTES);
	localparam int SLEN_W = 6;

	// summary queue between parser and run generator
	localparam int SUM_DEPTH = 4;
	localparam int SUM_PTR_W = $clog2(SUM_DEPTH);
	localparam int SUM_CNT_W = $clog2(SUM_DEPTH + 1);

	// SSID banks: queue depth + one draining + committed + pending, rounded up
	localparam int NUM_BANKS = 8;
	localparam int BANK_W    = $clog2(NUM_BANKS);
	localparam int RAM_AW    = BANK_W + SIDX_W;

	localparam logic [7:0] TAG_SSID     = 8'h00;
	localparam logic [7:0] TAG_RSN      = 8'h30;
	localparam logic [7:0] TAG_VENDOR   = 8'hdd;
	localparam logic [7:0] FC_TYPE_MASK = 8'hfc;
	localparam logic [7:0] FC_BEACON    = 8'h80;
	localparam logic [1:0] FC_TYPE_DATA = 2'b10;

	typedef enum logic [1:0] {
		KIND_BEACON  = 2'd0,
		KIND_TO_AP   = 2'd1,
		KIND_FROM_AP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ENC_OPEN = 2'd0,
		ENC_WPA  = 2'd1,
		ENC_WPA2 = 2'd2
	} enc_t;

	typedef enum logic [1:0] {
		PH_NUM  = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} tag_phase_t;

	typedef struct packed {
		kind_t              kind;
		logic [47:0]        bssid;
		logic [47:0]        station_mac;
		enc_t               enc;
		logic signed [7:0]  signal;
		logic [SLEN_W-1:0]  ssid_len;
		logic               trunc;
		logic [BANK_W-1:0]  bank;
	} summary_t;

	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} release_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

endpackage

[hw/rtl/wfbp_ssid_store.sv]
// Banked SSID byte store: one write port, one registered read port.
module wfbp_ssid_store (
	input  logic                       clk,
	input  wfbp_pkg::ram_wr_t          wr,
	input  logic                       rd_en,
	input  logic [wfbp_pkg::RAM_AW-1:0] rd_addr,
	output logic [7:0]                 rd_data
);

	logic [7:0] mem [wfbp_pkg::NUM_BANKS * wfbp_pkg::MAX_SSID_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/wfbp_front.sv]
// Byte parser: header capture, tag walk, SSID bank allocation, frame summaries.
module wfbp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           frame_byte,
	input  logic                 first_byte,
	input  logic                 final_byte,
	input  logic signed [7:0]    power_dbm,
	input  wfbp_pkg::release_t   rel,
	output logic                 sum_push,
	output wfbp_pkg::summary_t   sum_data,
	output wfbp_pkg::ram_wr_t    ram_wr
);

	logic [wfbp_pkg::POS_W-1:0]  pos_q, pos_d, pos;
	logic [7:0]                  fcl_q, fcl_d, fch_q, fch_d;
	logic [47:0]                 a1_q, a1_d, a2_q, a2_d, a3_q, a3_d;
	logic signed [7:0]           pwr_q, pwr_d;
	wfbp_pkg::tag_phase_t        phase_q, phase_d;
	logic [7:0]                  tnum_q, tnum_d, tleft_q, tleft_d, plen_q, plen_d;
	wfbp_pkg::enc_t              enc_q, enc_d;
	logic [wfbp_pkg::SLEN_W-1:0] clen_q, clen_d;
	logic                        trunc_q, trunc_d;
	logic [wfbp_pkg::BANK_W-1:0] comm_q, comm_d, pend_q, pend_d, free_bank;
	logic [wfbp_pkg::NUM_BANKS-1:0] busy_q, busy_d, free;
	logic [7:0]                  idx;
	logic                        finish, in_tags, beacon_end, data_end;

	always_comb begin
		pos_d    = pos_q;
		fcl_d    = fcl_q;
		fch_d    = fch_q;
		a1_d     = a1_q;
		a2_d     = a2_q;
		a3_d     = a3_q;
		pwr_d    = pwr_q;
		phase_d  = phase_q;
		tnum_d   = tnum_q;
		tleft_d  = tleft_q;
		plen_d   = plen_q;
		enc_d    = enc_q;
		clen_d   = clen_q;
		trunc_d  = trunc_q;
		comm_d   = comm_q;
		pend_d   = pend_q;
		ram_wr   = '0;
		sum_push = 1'b0;
		sum_data = '0;
		finish   = 1'b0;

		pos     = first_byte ? '0 : pos_q;
		in_tags = (pos >= wfbp_pkg::POS_W'(wfbp_pkg::TAGS_START))
			&& ((fcl_q & wfbp_pkg::FC_TYPE_MASK) == wfbp_pkg::FC_BEACON);
		idx     = plen_q - tleft_q;

		free = ~busy_q;
		free[comm_q] = 1'b0;
		free_bank = '0;
		for (int i = wfbp_pkg::NUM_BANKS - 1; i >= 0; i--) begin
			if (free[i]) begin
				free_bank = wfbp_pkg::BANK_W'(i);
			end
		end

		if (accept) begin
			if (pos == '0) begin
				fcl_d   = frame_byte;
				fch_d   = '0;
				pwr_d   = power_dbm;
				a1_d    = '0;
				a2_d    = '0;
				a3_d    = '0;
				phase_d = wfbp_pkg::PH_NUM;
				tnum_d  = '0;
				tleft_d = '0;
				enc_d   = wfbp_pkg::ENC_OPEN;
				clen_d  = '0;
				plen_d  = '0;
				trunc_d = 1'b0;
			end else if (pos == wfbp_pkg::POS_W'(1)) begin
				fch_d = frame_byte;
			end else if (pos >= wfbp_pkg::POS_W'(4) && pos < wfbp_pkg::POS_W'(10)) begin
				a1_d = {a1_q[39:0], frame_byte};
			end else if (pos >= wfbp_pkg::POS_W'(10) && pos < wfbp_pkg::POS_W'(16)) begin
				a2_d = {a2_q[39:0], frame_byte};
			end else if (pos >= wfbp_pkg::POS_W'(16) && pos < wfbp_pkg::POS_W'(22)) begin
				a3_d = {a3_q[39:0], frame_byte};
			end else if (in_tags) begin
				case (phase_q)
					wfbp_pkg::PH_LEN: begin
						plen_d  = frame_byte;
						tleft_d = frame_byte;
						if (frame_byte == '0) begin
							finish  = 1'b1;
							phase_d = wfbp_pkg::PH_NUM;
						end else begin
							phase_d = wfbp_pkg::PH_BODY;
						end
					end
					wfbp_pkg::PH_BODY: begin
						if (tnum_q == wfbp_pkg::TAG_SSID
							&& idx < 8'(wfbp_pkg::MAX_SSID_BYTES)) begin
							ram_wr.en   = 1'b1;
							ram_wr.addr = {pend_q, idx[wfbp_pkg::SIDX_W-1:0]};
							ram_wr.data = frame_byte;
						end
						tleft_d = tleft_q - 8'd1;
						if (tleft_q == 8'd1) begin
							finish  = 1'b1;
							phase_d = wfbp_pkg::PH_NUM;
						end
					end
					default: begin
						tnum_d  = frame_byte;
						phase_d = wfbp_pkg::PH_LEN;
						// fresh bank for each SSID tag; committed one stays intact
						if (frame_byte == wfbp_pkg::TAG_SSID) begin
							pend_d = free_bank;
						end
					end
				endcase
			end

			if (finish) begin
				if (tnum_q == wfbp_pkg::TAG_SSID) begin
					if (plen_d > 8'(wfbp_pkg::MAX_SSID_BYTES)) begin
						clen_d  = wfbp_pkg::SLEN_W'(wfbp_pkg::MAX_SSID_BYTES);
						trunc_d = 1'b1;
					end else begin
						clen_d  = plen_d[wfbp_pkg::SLEN_W-1:0];
						trunc_d = 1'b0;
					end
					comm_d = pend_q;
				end else if (tnum_q == wfbp_pkg::TAG_RSN) begin
					enc_d = wfbp_pkg::ENC_WPA2;
				end else if (tnum_q == wfbp_pkg::TAG_VENDOR) begin
					enc_d = wfbp_pkg::ENC_WPA;
				end
			end

			if (final_byte) begin
				pos_d = '0;
			end else if (pos < wfbp_pkg::POS_W'(wfbp_pkg::MAX_FRAME_BYTES)) begin
				pos_d = pos + wfbp_pkg::POS_W'(1);
			end else begin
				pos_d = pos;
			end

			beacon_end = (fcl_d & wfbp_pkg::FC_TYPE_MASK) == wfbp_pkg::FC_BEACON;
			data_end   = fcl_d[3:2] == wfbp_pkg::FC_TYPE_DATA;
			if (final_byte) begin
				if (beacon_end) begin
					if (pos >= wfbp_pkg::POS_W'(wfbp_pkg::TAGS_START - 1)) begin
						sum_push             = 1'b1;
						sum_data.kind        = wfbp_pkg::KIND_BEACON;
						sum_data.bssid       = a3_d;
						sum_data.station_mac = '0;
						sum_data.enc         = enc_d;
						sum_data.signal      = pwr_d;
						sum_data.ssid_len    = clen_d;
						sum_data.trunc       = trunc_d;
						sum_data.bank        = comm_d;
					end
				end else if (data_end && pos >= wfbp_pkg::POS_W'(wfbp_pkg::HDR_BYTES - 1)) begin
					// to-DS is bit 0 and from-DS bit 1 of the second control byte
					if (fch_d[0] && !fch_d[1]) begin
						sum_push             = 1'b1;
						sum_data.kind        = wfbp_pkg::KIND_TO_AP;
						sum_data.bssid       = a1_d;
						sum_data.station_mac = a2_d;
						sum_data.signal      = pwr_d;
					end else if (fch_d[1] && !fch_d[0]) begin
						sum_push             = 1'b1;
						sum_data.kind        = wfbp_pkg::KIND_FROM_AP;
						sum_data.bssid       = a2_d;
						sum_data.station_mac = a1_d;
						sum_data.signal      = pwr_d;
					end
				end
			end
		end else begin
			beacon_end = 1'b0;
			data_end   = 1'b0;
		end

		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (sum_push && sum_data.ssid_len != '0) begin
			busy_d[sum_data.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fcl_q   <= '0;
			fch_q   <= '0;
			a1_q    <= '0;
			a2_q    <= '0;
			a3_q    <= '0;
			pwr_q   <= '0;
			phase_q <= wfbp_pkg::PH_NUM;
			tnum_q  <= '0;
			tleft_q <= '0;
			plen_q  <= '0;
			enc_q   <= wfbp_pkg::ENC_OPEN;
			clen_q  <= '0;
			trunc_q <= 1'b0;
			comm_q  <= '0;
			pend_q  <= '0;
			busy_q  <= '0;
		end else begin
			pos_q   <= pos_d;
			fcl_q   <= fcl_d;
			fch_q   <= fch_d;
			a1_q    <= a1_d;
			a2_q    <= a2_d;
			a3_q    <= a3_d;
			pwr_q   <= pwr_d;
			phase_q <= phase_d;
			tnum_q  <= tnum_d;
			tleft_q <= tleft_d;
			plen_q  <= plen_d;
			enc_q   <= enc_d;
			clen_q  <= clen_d;
			trunc_q <= trunc_d;
			comm_q  <= comm_d;
			pend_q  <= pend_d;
			busy_q  <= busy_d;
		end
	end

endmodule

[hw/rtl/wfbp_sum_fifo.sv]
// Short queue of frame summaries between the parser and the run generator.
module wfbp_sum_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wfbp_pkg::summary_t push_data,
	input  logic               pop,
	output wfbp_pkg::summary_t head,
	output logic               full,
	output logic               empty
);

	wfbp_pkg::summary_t             entry_q [wfbp_pkg::SUM_DEPTH];
	logic [wfbp_pkg::SUM_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [wfbp_pkg::SUM_CNT_W-1:0] cnt_q;
	logic                           do_push, do_pop;

	assign full    = cnt_q == wfbp_pkg::SUM_CNT_W'(wfbp_pkg::SUM_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + wfbp_pkg::SUM_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + wfbp_pkg::SUM_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + wfbp_pkg::SUM_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - wfbp_pkg::SUM_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/wfbp_back.sv]
// Run generator: expands each summary into SSID results through a read stage and output queue.
module wfbp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  wfbp_pkg::summary_t          q_head,
	output logic                        q_pop,
	output wfbp_pkg::release_t          rel,
	output logic                        rd_en,
	output logic [wfbp_pkg::RAM_AW-1:0] rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  frame_kind,
	output logic [47:0]                 bssid,
	output logic [47:0]                 station_mac,
	output logic [1:0]                  encryption,
	output logic signed [7:0]           signal_dbm,
	output logic [5:0]                  ssid_length,
	output logic                        ssid_truncated,
	output logic [4:0]                  ssid_index,
	output logic [7:0]                  ssid_byte,
	output logic                        last_of_run
);

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		wfbp_pkg::kind_t               kind;
		logic [47:0]                   bssid;
		logic [47:0]                   station_mac;
		wfbp_pkg::enc_t                enc;
		logic signed [7:0]             signal;
		logic [wfbp_pkg::SLEN_W-1:0]   ssid_len;
		logic                          trunc;
		logic [wfbp_pkg::SIDX_W-1:0]   index;
		logic                          last;
	} res_t;

	typedef struct packed {
		res_t       res;
		logic [7:0] data;
	} out_t;

	wfbp_pkg::summary_t            cur_q;
	logic                          cur_v_q;
	logic [wfbp_pkg::SIDX_W-1:0]   k_q;
	logic [wfbp_pkg::SLEN_W-1:0]   run_len;
	logic                          last, issue;
	res_t                          res_s1;
	logic                          v_s1, zero_s1;
	out_t                          out_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]          owr_q, ord_q;
	logic [OUT_CNT_W-1:0]          ocnt_q;
	logic                          opush, opop;
	out_t                          ohead;

	// hidden SSID and data frames still give one result
	assign run_len = (cur_q.ssid_len == '0) ? wfbp_pkg::SLEN_W'(1) : cur_q.ssid_len;
	assign last    = ({1'b0, k_q} + wfbp_pkg::SLEN_W'(1)) == run_len;
	assign issue   = cur_v_q
		&& ((ocnt_q + OUT_CNT_W'(v_s1)) < OUT_CNT_W'(OUT_DEPTH));
	assign q_pop   = !q_empty && (!cur_v_q || (issue && last));
	assign rd_en   = issue;
	assign rd_addr = {cur_q.bank, k_q};

	assign rel.valid = issue && last && cur_q.ssid_len != '0;
	assign rel.bank  = cur_q.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			cur_v_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (q_pop) begin
				cur_q   <= q_head;
				cur_v_q <= 1'b1;
			end else if (issue && last) begin
				cur_v_q <= 1'b0;
			end
			if (issue) begin
				k_q <= last ? '0 : k_q + wfbp_pkg::SIDX_W'(1);
			end
		end
	end

	// read stage: lines up with the registered store output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_s1  <= '0;
			zero_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				res_s1.kind        <= cur_q.kind;
				res_s1.bssid       <= cur_q.bssid;
				res_s1.station_mac <= cur_q.station_mac;
				res_s1.enc         <= cur_q.enc;
				res_s1.signal      <= cur_q.signal;
				res_s1.ssid_len    <= cur_q.ssid_len;
				res_s1.trunc       <= cur_q.trunc;
				res_s1.index       <= k_q;
				res_s1.last        <= last;
				zero_s1            <= cur_q.ssid_len == '0;
			end
		end
	end

	assign opush = v_s1;
	assign opop  = pop && !empty;
	assign empty = ocnt_q == '0;
	assign ohead = out_q[ord_q];

	always_ff @(posedge clk) begin
		if (opush) begin
			out_q[owr_q] <= '{res: res_s1, data: zero_s1 ? 8'd0 : rd_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owr_q <= owr_q + OUT_PTR_W'(1);
			end
			if (opop) begin
				ord_q <= ord_q + OUT_PTR_W'(1);
			end
			case ({opush, opop})
				2'b10:   ocnt_q <= ocnt_q + OUT_CNT_W'(1);
				2'b01:   ocnt_q <= ocnt_q - OUT_CNT_W'(1);
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assign frame_kind     = ohead.res.kind;
	assign bssid          = ohead.res.bssid;
	assign station_mac    = ohead.res.station_mac;
	assign encryption     = ohead.res.enc;
	assign signal_dbm     = ohead.res.signal;
	assign ssid_length    = ohead.res.ssid_len;
	assign ssid_truncated = ohead.res.trunc;
	assign ssid_index     = ohead.res.index;
	assign ssid_byte      = ohead.data;
	assign last_of_run    = ohead.res.last;

endmodule

[hw/rtl/wifi_frame_beacon_parser.sv]
// Top level of the 802.11 beacon and data frame summariser.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  bytes in | push / full          | frame_byte, first_byte, final_byte, power_dbm
//  results  | empty / pop          | frame_kind .. ssid_byte, last_of_run
//
// One frame byte is taken every cycle while full is low; the parser has no
// multi-cycle step. A frame's results pass through the summary queue, the current summary
// register, the read stage and a four-deep output queue, and leave at up to one per pop.
// full rises while four frame summaries wait; their SSID runs hold store banks.
// Reset leaves every queue empty and no store clearing is needed.
module wifi_frame_beacon_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        frame_byte,
	input  logic              first_byte,
	input  logic              final_byte,
	input  logic signed [7:0] power_dbm,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        frame_kind,
	output logic [47:0]       bssid,
	output logic [47:0]       station_mac,
	output logic [1:0]        encryption,
	output logic signed [7:0] signal_dbm,
	output logic [5:0]        ssid_length,
	output logic              ssid_truncated,
	output logic [4:0]        ssid_index,
	output logic [7:0]        ssid_byte,
	output logic              last_of_run
);

	logic                        accept;
	logic                        sum_push, q_pop, q_empty, q_full;
	wfbp_pkg::summary_t          sum_data, q_head;
	wfbp_pkg::release_t          rel;
	wfbp_pkg::ram_wr_t           ram_wr;
	logic                        rd_en;
	logic [wfbp_pkg::RAM_AW-1:0] rd_addr;
	logic [7:0]                  rd_data;

	assign full   = q_full;
	assign accept = push && !q_full;

	wfbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.first_byte (first_byte),
		.final_byte (final_byte),
		.power_dbm  (power_dbm),
		.rel        (rel),
		.sum_push   (sum_push),
		.sum_data   (sum_data),
		.ram_wr     (ram_wr)
	);

	wfbp_ssid_store u_store (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wfbp_sum_fifo u_sum_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sum_push),
		.push_data (sum_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	wfbp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.rel            (rel),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.empty          (empty),
		.pop            (pop),
		.frame_kind     (frame_kind),
		.bssid          (bssid),
		.station_mac    (station_mac),
		.encryption     (encryption),
		.signal_dbm     (signal_dbm),
		.ssid_length    (ssid_length),
		.ssid_truncated (ssid_truncated),
		.ssid_index     (ssid_index),
		.ssid_byte      (ssid_byte),
		.last_of_run    (last_of_run)
	);

endmodule

[hw/rtl/wfbp_checker.sv]
// Port-level checks on the result queue of the beacon parser, bound to the top level.
module wfbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  frame_kind,
	input logic [47:0] bssid,
	input logic [1:0]  encryption,
	input logic [5:0]  ssid_length,
	input logic [4:0]  ssid_index,
	input logic        last_of_run
);

	// a waiting result is not withdrawn and keeps its index and BSSID
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(ssid_index) && $stable(bssid)))
		else $error("stalled result changed");

	// data frames carry no SSID or encryption and end their run at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_kind != wfbp_pkg::KIND_BEACON)
		|-> (ssid_length == 6'd0 && encryption == wfbp_pkg::ENC_OPEN && last_of_run))
		else $error("data frame result with SSID fields");

	// positions stay inside the stored SSID
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ssid_length != 6'd0) |-> ({1'b0, ssid_index} < ssid_length))
		else $error("SSID index past stored length");

	// a run closes exactly at the last stored byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ssid_length != 6'd0)
		|-> (last_of_run == (({1'b0, ssid_index} + 6'd1) == ssid_length)))
		else $error("run end marker misplaced");

	// stored length never exceeds the store
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (ssid_length <= 6'(wfbp_pkg::MAX_SSID_BYTES)))
		else $error("SSID length beyond store");

endmodule

bind wifi_frame_beacon_parser wfbp_checker u_wfbp_checker (.*);

[bench/frame_summary_checker.sv]
`timescale 1ns / 100ps
// Frame summary predictor and result checker for the beacon parser bench.
module frame_summary_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [7:0]        frame_byte,
	input  logic              first_byte,
	input  logic              final_byte,
	input  logic signed [7:0] power_dbm,
	input  logic              empty,
	input  logic              pop,
	input  logic [1:0]        frame_kind,
	input  logic [47:0]       bssid,
	input  logic [47:0]       station_mac,
	input  logic [1:0]        encryption,
	input  logic signed [7:0] signal_dbm,
	input  logic [5:0]        ssid_length,
	input  logic              ssid_truncated,
	input  logic [4:0]        ssid_index,
	input  logic [7:0]        ssid_byte,
	input  logic              last_of_run,
	output int                fail_count,
	output int                waiting
);

	typedef struct packed {
		wfbp_pkg::kind_t   kind;
		logic [47:0]       bssid;
		logic [47:0]       station_mac;
		wfbp_pkg::enc_t    enc;
		logic signed [7:0] signal;
		logic [5:0]        ssid_len;
		logic              trunc;
		logic [4:0]        idx;
		logic [7:0]        sbyte;
		logic              last;
	} result_rec_t;

	result_rec_t summary_due_q[$];
	result_rec_t want_rec;

	// parser state as the frame is walked
	logic [wfbp_pkg::POS_W-1:0]  pos_cnt;
	logic [7:0]                  fc_lo;
	logic [7:0]                  fc_hi;
	logic [47:0]                 addr1;
	logic [47:0]                 addr2;
	logic [47:0]                 addr3;
	logic signed [7:0]           held_pwr;
	wfbp_pkg::tag_phase_t        phase;
	logic [7:0]                  tag_num;
	logic [7:0]                  tag_left;
	wfbp_pkg::enc_t              enc_now;
	logic [7:0]                  ssid_now [wfbp_pkg::MAX_SSID_BYTES];
	logic [wfbp_pkg::SLEN_W-1:0] ssid_len_now;
	logic                        trunc_now;
	logic [7:0]                  ssid_buf [wfbp_pkg::MAX_SSID_BYTES];
	logic [7:0]                  buf_len;
	int                          errors = 0;

	function automatic void start_frame(input logic [7:0] b, input logic signed [7:0] p);
		fc_lo = b;
		fc_hi = '0;
		held_pwr = p;
		addr1 = '0;
		addr2 = '0;
		addr3 = '0;
		phase = wfbp_pkg::PH_NUM;
		tag_num = '0;
		tag_left = '0;
		enc_now = wfbp_pkg::ENC_OPEN;
		ssid_len_now = '0;
		buf_len = '0;
		trunc_now = 1'b0;
	endfunction

	// a tag acts only once its last body byte is in
	function automatic void commit_tag();
		int keep;
		if (tag_num == wfbp_pkg::TAG_SSID) begin
			keep = (buf_len > wfbp_pkg::MAX_SSID_BYTES) ? wfbp_pkg::MAX_SSID_BYTES : buf_len;
			for (int i = 0; i < keep; i++)
				ssid_now[i] = ssid_buf[i];
			ssid_len_now = wfbp_pkg::SLEN_W'(keep);
			trunc_now = buf_len > wfbp_pkg::MAX_SSID_BYTES;
		end else if (tag_num == wfbp_pkg::TAG_RSN) begin
			enc_now = wfbp_pkg::ENC_WPA2;
		end else if (tag_num == wfbp_pkg::TAG_VENDOR) begin
			enc_now = wfbp_pkg::ENC_WPA;
		end
	endfunction

	function automatic void step_tag(input logic [7:0] b);
		int slot;
		case (phase)
			wfbp_pkg::PH_LEN: begin
				buf_len = b;
				tag_left = b;
				if (b == 0) begin
					commit_tag();
					phase = wfbp_pkg::PH_NUM;
				end else begin
					phase = wfbp_pkg::PH_BODY;
				end
			end
			wfbp_pkg::PH_BODY: begin
				if (tag_num == wfbp_pkg::TAG_SSID) begin
					slot = buf_len - tag_left;
					if (slot < wfbp_pkg::MAX_SSID_BYTES)
						ssid_buf[slot] = b;
				end
				tag_left--;
				if (tag_left == 0) begin
					commit_tag();
					phase = wfbp_pkg::PH_NUM;
				end
			end
			default: begin
				tag_num = b;
				phase = wfbp_pkg::PH_LEN;
			end
		endcase
	endfunction

	function automatic void add_result(input wfbp_pkg::kind_t kind, input logic [47:0] bss,
			input logic [47:0] sta, input wfbp_pkg::enc_t enc, input logic [5:0] slen,
			input logic trunc, input logic [4:0] idx, input logic [7:0] sb, input logic last);
		result_rec_t r;
		r.kind = kind;
		r.bssid = bss;
		r.station_mac = sta;
		r.enc = enc;
		r.signal = held_pwr;
		r.ssid_len = slen;
		r.trunc = trunc;
		r.idx = idx;
		r.sbyte = sb;
		r.last = last;
		summary_due_q.push_back(r);
	endfunction

	function automatic void absorb_frame_byte(input logic [7:0] b, input logic f,
			input logic l, input logic signed [7:0] p);
		logic [wfbp_pkg::POS_W-1:0] len;
		if (f)
			pos_cnt = '0;
		if (pos_cnt == 0)
			start_frame(b, p);
		else if (pos_cnt == 1)
			fc_hi = b;
		else if (pos_cnt >= 4 && pos_cnt < 10)
			addr1 = {addr1[39:0], b};
		else if (pos_cnt >= 10 && pos_cnt < 16)
			addr2 = {addr2[39:0], b};
		else if (pos_cnt >= 16 && pos_cnt < 22)
			addr3 = {addr3[39:0], b};
		else if (pos_cnt >= wfbp_pkg::TAGS_START
				&& (fc_lo & wfbp_pkg::FC_TYPE_MASK) == wfbp_pkg::FC_BEACON)
			step_tag(b);
		// the count saturates on long frames; tag walking carries on
		if (pos_cnt < wfbp_pkg::MAX_FRAME_BYTES)
			pos_cnt++;
		if (!l)
			return;
		len = pos_cnt;
		pos_cnt = '0;
		if ((fc_lo & wfbp_pkg::FC_TYPE_MASK) == wfbp_pkg::FC_BEACON) begin
			if (len >= wfbp_pkg::TAGS_START) begin
				if (ssid_len_now == 0)
					add_result(wfbp_pkg::KIND_BEACON, addr3, '0, enc_now, '0, trunc_now,
						'0, '0, 1'b1);
				else
					for (int k = 0; k < ssid_len_now; k++)
						add_result(wfbp_pkg::KIND_BEACON, addr3, '0, enc_now, ssid_len_now,
							trunc_now, 5'(k), ssid_now[k], k + 1 == ssid_len_now);
			end
		end else if (fc_lo[3:2] == wfbp_pkg::FC_TYPE_DATA && len >= wfbp_pkg::HDR_BYTES) begin
			// WDS and ad-hoc (both or neither DS bit) give nothing
			if (fc_hi[0] && !fc_hi[1])
				add_result(wfbp_pkg::KIND_TO_AP, addr1, addr2, wfbp_pkg::ENC_OPEN, '0, 1'b0,
					'0, '0, 1'b1);
			else if (fc_hi[1] && !fc_hi[0])
				add_result(wfbp_pkg::KIND_FROM_AP, addr2, addr1, wfbp_pkg::ENC_OPEN, '0, 1'b0,
					'0, '0, 1'b1);
		end
	endfunction

	task automatic report(input string msg);
		errors++;
		$display("%0t ns checker: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt = '0;
			start_frame(8'h00, 8'sh00);
			summary_due_q.delete();
		end else begin
			if (push && !full)
				absorb_frame_byte(frame_byte, first_byte, final_byte, power_dbm);
			if (pop && !empty) begin
				if (summary_due_q.size() == 0) begin
					report("result transfer with nothing expected");
				end else begin
					want_rec = summary_due_q.pop_front();
					check_field("frame_kind", frame_kind, want_rec.kind);
					check_field("bssid", bssid, want_rec.bssid);
					check_field("station_mac", station_mac, want_rec.station_mac);
					check_field("encryption", encryption, want_rec.enc);
					check_field("signal_dbm", $unsigned(signal_dbm), $unsigned(want_rec.signal));
					check_field("ssid_length", ssid_length, want_rec.ssid_len);
					check_field("ssid_truncated", ssid_truncated, want_rec.trunc);
					check_field("ssid_index", ssid_index, want_rec.idx);
					check_field("ssid_byte", ssid_byte, want_rec.sbyte);
					check_field("last_of_run", last_of_run, want_rec.last);
				end
			end
		end
		waiting <= summary_due_q.size();
		fail_count <= errors;
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Top of the beacon parser bench: clock, reset, frame stimulus and verdict.
module tb_top;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [7:0]        frame_byte;
	logic              first_byte;
	logic              final_byte;
	logic signed [7:0] power_dbm;
	logic              empty;
	logic              pop;
	logic [1:0]        frame_kind;
	logic [47:0]       bssid;
	logic [47:0]       station_mac;
	logic [1:0]        encryption;
	logic signed [7:0] signal_dbm;
	logic [5:0]        ssid_length;
	logic              ssid_truncated;
	logic [4:0]        ssid_index;
	logic [7:0]        ssid_byte;
	logic              last_of_run;
	int                fail_count;
	int                waiting;

	logic [7:0]        frame_q[$];
	int                burst_left = 0;
	int                sent_bytes = 0;
	logic [15:0]       pop_pattern = 16'hffff;
	logic [7:0]        pop_step = '0;

	wifi_frame_beacon_parser u_top (.*);

	frame_summary_checker u_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: pops follow a random 16-bit pattern, redrawn whenever the low six step bits are all ones
	always @(posedge clk) begin
		pop_step <= pop_step + 1'b1;
		if (pop_step[5:0] == 6'd63) begin
			case ($urandom_range(0, 3))
				0: pop_pattern <= 16'hffff;
				1: pop_pattern <= 16'h0001 << $urandom_range(0, 15);
				default: pop_pattern <= 16'($urandom) | 16'h0101;
			endcase
		end
		pop <= pop_pattern[pop_step[3:0]];
	end

	function automatic logic [47:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return r[47:0];
		endcase
	endfunction

	function automatic logic [7:0] pick_tag();
		case ($urandom_range(0, 2))
			0: return wfbp_pkg::TAG_SSID;
			1: return wfbp_pkg::TAG_RSN;
			default: return wfbp_pkg::TAG_VENDOR;
		endcase
	endfunction

	// one byte transfer; the sender runs in bursts with random gaps
	task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
			input logic signed [7:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		frame_byte <= b;
		first_byte <= f;
		final_byte <= l;
		power_dbm <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent_bytes++;
	endtask

	task automatic add_pad(input int n);
		for (int i = 0; i < n; i++)
			frame_q.push_back(8'($urandom));
	endtask

	task automatic add_header(input logic [7:0] fl, input logic [7:0] fh,
			input logic [47:0] a1, input logic [47:0] a2, input logic [47:0] a3);
		frame_q.push_back(fl);
		frame_q.push_back(fh);
		add_pad(2);
		for (int i = 47; i >= 0; i -= 8)
			frame_q.push_back(a1[i -: 8]);
		for (int i = 47; i >= 0; i -= 8)
			frame_q.push_back(a2[i -: 8]);
		for (int i = 47; i >= 0; i -= 8)
			frame_q.push_back(a3[i -: 8]);
		add_pad(2);
	endtask

	// body shorter than len leaves the tag open at frame end
	task automatic add_tag(input logic [7:0] num, input int len, input int body);
		frame_q.push_back(num);
		frame_q.push_back(8'(len));
		add_pad(body);
	endtask

	task automatic send_frame(input logic signed [7:0] p, input logic mf, input logic ml);
		int n;
		n = frame_q.size();
		for (int i = 0; i < n; i++)
			send_byte(frame_q[i], mf && i == 0, ml && i == n - 1, (i == 0) ? p : 8'($urandom));
		frame_q.delete();
	endtask

	initial begin
		int goal;
		int kind;
		int ntags;
		int sel;
		int len;
		int cut;
		logic [7:0] fl;

		push = 1'b0;
		frame_byte = '0;
		first_byte = 1'b0;
		final_byte = 1'b0;
		power_dbm = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first frame after reset carries no start mark
		add_header(wfbp_pkg::FC_BEACON, 8'h00, rand_mac(), rand_mac(), 48'hffff_ffff_ffff);
		add_pad(wfbp_pkg::FIXED_BYTES);
		add_tag(wfbp_pkg::TAG_SSID, 4, 4);
		send_frame(8'sh7f, 1'b0, 1'b1);
		// full SSID store; the last security tag wins
		add_header(wfbp_pkg::FC_BEACON, 8'h00, rand_mac(), rand_mac(), 48'h0);
		add_pad(wfbp_pkg::FIXED_BYTES);
		add_tag(wfbp_pkg::TAG_SSID, wfbp_pkg::MAX_SSID_BYTES, wfbp_pkg::MAX_SSID_BYTES);
		add_tag(wfbp_pkg::TAG_VENDOR, 1, 1);
		add_tag(wfbp_pkg::TAG_RSN, 1, 1);
		add_tag(wfbp_pkg::TAG_VENDOR, 1, 1);
		send_frame(8'sh00, 1'b1, 1'b1);
		// over-long SSID gets truncated
		add_header(wfbp_pkg::FC_BEACON, 8'h00, rand_mac(), rand_mac(), rand_mac());
		add_pad(wfbp_pkg::FIXED_BYTES);
		add_tag(wfbp_pkg::TAG_SSID, 40, 40);
		send_frame(8'sh10, 1'b1, 1'b1);
		// one-byte frame
		send_byte(wfbp_pkg::FC_BEACON, 1'b1, 1'b1, 8'sh03);

		goal = 380;
		while (sent_bytes < goal) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				add_header(wfbp_pkg::FC_BEACON | 8'($urandom_range(0, 3)), 8'($urandom),
					rand_mac(), rand_mac(), rand_mac());
				add_pad(wfbp_pkg::FIXED_BYTES);
				ntags = $urandom_range(0, 5);
				for (int k = 0; k < ntags; k++) begin
					sel = $urandom_range(0, 9);
					if (sel < 4) begin
						len = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 12) :
							$urandom_range(28, 40);
						add_tag(wfbp_pkg::TAG_SSID, len, len);
					end else if (sel < 6) begin
						len = $urandom_range(1, 20);
						add_tag(wfbp_pkg::TAG_RSN, len, len);
					end else if (sel < 8) begin
						len = $urandom_range(1, 12);
						add_tag(wfbp_pkg::TAG_VENDOR, len, len);
					end else if (sel == 8) begin
						len = $urandom_range(0, 10);
						add_tag(8'($urandom), len, len);
					end else begin
						add_tag(pick_tag(), 0, 0);
					end
				end
				// unfinished trailing tag
				if ($urandom_range(0, 3) == 0) begin
					if ($urandom_range(0, 1) == 0) begin
						frame_q.push_back(pick_tag());
					end else begin
						len = $urandom_range(1, 12);
						add_tag(pick_tag(), len, $urandom_range(0, len - 1));
					end
				end
				if ($urandom_range(0, 9) == 0) begin
					cut = $urandom_range(wfbp_pkg::HDR_BYTES, wfbp_pkg::TAGS_START - 1);
					while (frame_q.size() > cut)
						void'(frame_q.pop_back());
				end
				send_frame(8'($urandom), $urandom_range(0, 7) != 0, $urandom_range(0, 15) != 0);
			end else if (kind < 8) begin
				fl = {4'($urandom), wfbp_pkg::FC_TYPE_DATA, 2'($urandom)};
				add_header(fl, 8'($urandom), rand_mac(), rand_mac(), rand_mac());
				add_pad($urandom_range(0, 8));
				if ($urandom_range(0, 7) == 0) begin
					cut = $urandom_range(18, wfbp_pkg::HDR_BYTES - 1);
					while (frame_q.size() > cut)
						void'(frame_q.pop_back());
				end
				send_frame(8'($urandom), $urandom_range(0, 7) != 0, $urandom_range(0, 15) != 0);
			end else if (kind == 8) begin
				do
					fl = 8'($urandom);
				while (fl[3:2] == wfbp_pkg::FC_TYPE_DATA
					|| (fl & wfbp_pkg::FC_TYPE_MASK) == wfbp_pkg::FC_BEACON);
				add_header(fl, 8'($urandom), rand_mac(), rand_mac(), rand_mac());
				add_pad($urandom_range(0, 20));
				send_frame(8'($urandom), $urandom_range(0, 7) != 0, $urandom_range(0, 15) != 0);
			end else begin
				// loose bytes with stray marks
				len = $urandom_range(1, 30);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom), $urandom_range(0, 7) == 0,
						$urandom_range(0, 7) == 0, 8'($urandom));
			end
		end
		push <= 1'b0;

		@(posedge clk);
		for (int t = 0; t < 400000 && waiting != 0; t++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && waiting == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
